// ===== rtl/tgi_pkg.sv =====
`timescale 1ns / 1ps
package tgi_pkg;

   // Grid geometry
   localparam int ANGLE_POINTS = 18;
   localparam int DIST_POINTS  = 11;
   localparam int GRID_SIZE    = ANGLE_POINTS * DIST_POINTS * DIST_POINTS;
   localparam int ADDR_W       = $clog2(GRID_SIZE);
   localparam int ANG_IDX_W    = $clog2(ANGLE_POINTS);
   localparam int DIST_IDX_W   = $clog2(DIST_POINTS);

   // Fixed-point widths
   localparam int FRAC_W = 9;   // corner fraction 0..256
   localparam int WAC_W  = 17;  // product of two weights, up to 2^16
   localparam int W_W    = 25;  // product of three weights, up to 2^24
   localparam int ACC_W  = 40;  // weighted sum, below 2^40

   localparam logic [15:0] ANGLE_TOP = 16'((ANGLE_POINTS - 1) * 256);
   localparam logic [15:0] ANGLE_CAP = 16'(ANGLE_POINTS - 2);
   localparam logic [15:0] DIST_TOP  = 16'((DIST_POINTS - 1) * 256);
   localparam logic [15:0] DIST_CAP  = 16'(DIST_POINTS - 2);

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_ANGLE_ORIGIN = 3'd0;
   localparam logic [2:0] CSR_ANGLE_SCALE  = 3'd1;
   localparam logic [2:0] CSR_DIST_ORIGIN  = 3'd2;
   localparam logic [2:0] CSR_DIST_SCALE   = 3'd3;
   localparam logic [2:0] CSR_TABLE_READY  = 3'd4;

   // Request action codes
   localparam logic ACT_QUERY = 1'b0;
   localparam logic ACT_LOAD  = 1'b1;

   typedef struct packed {
      logic signed [15:0] angle_origin;
      logic [15:0]        angle_scale;
      logic [15:0]        dist_origin;
      logic [15:0]        dist_scale;
      logic               table_ready;
   } cfg_type;

   typedef struct packed {
      logic       write;     // store one grid entry from the request
      logic       capture;   // latch query fields
      logic       prod;      // form scaled positions
      logic       locate;    // clamp, split into index and fraction
      logic       base;      // form base address, clear accumulator
      logic       issue;     // read one corner
      logic [2:0] corner;    // corner being read
      logic       load_out;  // move result into output register
   } cmd_type;

   typedef struct packed {
      logic [15:0]       idx;
      logic [FRAC_W-1:0] frac;
   } axis_type;

   // Clamp a position to the grid and split it into lower index and fraction
   function automatic axis_type axis_locate(logic [15:0] pos, logic [15:0] top,
                                            logic [15:0] cap);
      logic [15:0] p;
      logic [15:0] i0;
      axis_type    r;
      p  = (pos > top) ? top : pos;
      i0 = {8'd0, p[15:8]};
      if (i0 > cap) begin
         i0 = cap;
      end
      r.idx  = i0;
      r.frac = FRAC_W'(p - {i0[7:0], 8'd0});
      return r;
   endfunction

   // Flat address offset of a corner: bit 2 angle, bit 1 first, bit 0 second distance
   function automatic logic [ADDR_W-1:0] corner_offset(logic [2:0] k);
      logic [ADDR_W-1:0] off;
      off = '0;
      if (k[2]) begin
         off = off + ADDR_W'(DIST_POINTS * DIST_POINTS);
      end
      if (k[1]) begin
         off = off + ADDR_W'(DIST_POINTS);
      end
      if (k[0]) begin
         off = off + ADDR_W'(1);
      end
      return off;
   endfunction

endpackage

// ===== rtl/trilinear_grid_interpolator.sv =====
`timescale 1ns / 1ps
// Trilinear grid interpolator.
// Request channel (req_*): req_action selects a load, which stores
// req_entry_value at flat index req_entry_index, or a query, which
// interpolates the grid at req_cut_angle, req_dist_cue_obj and
// req_dist_obj_pocket. A load gives no response; an index past the grid
// is dropped. A query gives one response on rsp_pot_probability, zero
// while table_ready is clear.
// A load is written in the cycle it is accepted and leaves the block idle.
// From acceptance to rsp_valid a query passes through setup steps (scale,
// clamp, address), eight corner reads from the single-port grid memory
// feeding one shared multiply-accumulate, a pipeline drain and an output step.
// The next request is taken the cycle after the result is registered.
// The result sits in an output register; if the receiver stalls, a new
// query runs to completion and then waits for that register to empty.
// Configuration (csr_*) is always ready; write it only while idle.
// Synchronous reset returns the sequencer to idle, drops any pending
// response and restores register defaults. Grid contents are not cleared.
module trilinear_grid_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [15:0] req_cut_angle,
   input  logic [15:0]        req_dist_cue_obj,
   input  logic [15:0]        req_dist_obj_pocket,
   input  logic [11:0]        req_entry_index,
   input  logic [15:0]        req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_pot_probability,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import tgi_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ANGLE_ORIGIN: cfg_in.angle_origin = csr_wdata;
            CSR_ANGLE_SCALE:  cfg_in.angle_scale  = csr_wdata;
            CSR_DIST_ORIGIN:  cfg_in.dist_origin  = csr_wdata;
            CSR_DIST_SCALE:   cfg_in.dist_scale   = csr_wdata;
            CSR_TABLE_READY:  cfg_in.table_ready  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_origin <= 16'sd0;
         cfg_ff.angle_scale  <= 16'd52429;
         cfg_ff.dist_origin  <= 16'd1600;
         cfg_ff.dist_scale   <= 16'd13107;
         cfg_ff.table_ready  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   tgi_datapath u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .cfg                 (cfg_ff),
      .req_cut_angle       (req_cut_angle),
      .req_dist_cue_obj    (req_dist_cue_obj),
      .req_dist_obj_pocket (req_dist_obj_pocket),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .rsp_pot_probability (rsp_pot_probability)
   );

endmodule

// ===== rtl/tgi_ctrl.sv =====
`timescale 1ns / 1ps
module tgi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tgi_pkg::cmd_type cmd
);
   import tgi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROD   = 3'd1;
   localparam logic [2:0] ST_LOCATE = 3'd2;
   localparam logic [2:0] ST_BASE   = 3'd3;
   localparam logic [2:0] ST_STREAM = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] corner_ff, corner_in;
   logic       drain_ff, drain_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one request through the datapath
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.corner = corner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = ST_BASE;
         end
         ST_BASE: begin
            cmd.base  = 1'b1;
            corner_in = '0;
            state_in  = ST_STREAM;
         end
         ST_STREAM: begin
            cmd.issue = 1'b1;
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'd7) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until the receiver takes it
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/tgi_datapath.sv =====
`timescale 1ns / 1ps
module tgi_datapath (
   input  logic               clock,
   input  tgi_pkg::cmd_type   cmd,
   input  tgi_pkg::cfg_type   cfg,
   input  logic signed [15:0] req_cut_angle,
   input  logic [15:0]        req_dist_cue_obj,
   input  logic [15:0]        req_dist_obj_pocket,
   input  logic [11:0]        req_entry_index,
   input  logic [15:0]        req_entry_value,
   output logic [15:0]        rsp_pot_probability
);
   import tgi_pkg::*;

   logic [15:0] grid_mem [GRID_SIZE];

   logic signed [15:0]    angle_ff;
   logic [15:0]           dist_a_ff, dist_b_ff;
   logic [15:0]           pos_a_ff, pos_c_ff, pos_p_ff;
   logic [15:0]           pos_a_in, pos_c_in, pos_p_in;
   logic [ANG_IDX_W-1:0]  ia_ff;
   logic [DIST_IDX_W-1:0] ic_ff, ip_ff;
   logic [FRAC_W-1:0]     fa_ff, fc_ff, fp_ff;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [15:0]           rd_data_ff, data2_ff;
   logic [WAC_W-1:0]      wac_ff, wac_in;
   logic                  dk_ff;
   logic                  v1_ff, v2_ff;
   logic [W_W-1:0]        w_ff, w_in;
   logic [ACC_W-1:0]      acc_ff;
   logic [15:0]           out_ff;
   axis_type              loc_a, loc_c, loc_p;
   logic signed [16:0]    diff_a, diff_c, diff_p;
   logic [31:0]           prod_a, prod_c, prod_p;
   logic [FRAC_W-1:0]     wa_sel, wc_sel, wp_sel;
   logic                  load_ok;

   // Axis offsets from origin, exact in 17 bits
   assign diff_a = {angle_ff[15], angle_ff} - {cfg.angle_origin[15], cfg.angle_origin};
   assign diff_c = {1'b0, dist_a_ff} - {1'b0, cfg.dist_origin};
   assign diff_p = {1'b0, dist_b_ff} - {1'b0, cfg.dist_origin};

   assign prod_a = diff_a[15:0] * cfg.angle_scale;
   assign prod_c = diff_c[15:0] * cfg.dist_scale;
   assign prod_p = diff_p[15:0] * cfg.dist_scale;

   // Zero position where the offset is not positive
   assign pos_a_in = (!diff_a[16] && diff_a != '0) ? prod_a[31:16] : 16'd0;
   assign pos_c_in = (!diff_c[16] && diff_c != '0) ? prod_c[31:16] : 16'd0;
   assign pos_p_in = (!diff_p[16] && diff_p != '0) ? prod_p[31:16] : 16'd0;

   assign loc_a = axis_locate(pos_a_ff, ANGLE_TOP, ANGLE_CAP);
   assign loc_c = axis_locate(pos_c_ff, DIST_TOP, DIST_CAP);
   assign loc_p = axis_locate(pos_p_ff, DIST_TOP, DIST_CAP);

   assign base_in = ADDR_W'((ADDR_W'(ia_ff) * ADDR_W'(DIST_POINTS) + ADDR_W'(ic_ff))
                            * ADDR_W'(DIST_POINTS)) + ADDR_W'(ip_ff);

   // Corner weights: fraction for the upper point, its complement for the lower
   assign wa_sel = cmd.corner[2] ? fa_ff : FRAC_W'(9'd256 - fa_ff);
   assign wc_sel = cmd.corner[1] ? fc_ff : FRAC_W'(9'd256 - fc_ff);
   assign wp_sel = dk_ff ? fp_ff : FRAC_W'(9'd256 - fp_ff);
   assign wac_in = WAC_W'(wa_sel) * WAC_W'(wc_sel);
   assign w_in   = W_W'(wac_ff) * W_W'(wp_sel);

   assign load_ok = cmd.write && (32'(req_entry_index) < 32'(GRID_SIZE));

   // Single-port grid memory: load writes, corner reads
   always_ff @(posedge clock) begin
      if (load_ok) begin
         grid_mem[ADDR_W'(req_entry_index)] <= req_entry_value;
      end else if (cmd.issue) begin
         rd_data_ff <= grid_mem[base_ff + corner_offset(cmd.corner)];
      end
   end

   // Query setup stages
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         angle_ff  <= req_cut_angle;
         dist_a_ff <= req_dist_cue_obj;
         dist_b_ff <= req_dist_obj_pocket;
      end
      if (cmd.prod) begin
         pos_a_ff <= pos_a_in;
         pos_c_ff <= pos_c_in;
         pos_p_ff <= pos_p_in;
      end
      if (cmd.locate) begin
         ia_ff <= ANG_IDX_W'(loc_a.idx);
         ic_ff <= DIST_IDX_W'(loc_c.idx);
         ip_ff <= DIST_IDX_W'(loc_p.idx);
         fa_ff <= loc_a.frac;
         fc_ff <= loc_c.frac;
         fp_ff <= loc_p.frac;
      end
      if (cmd.base) begin
         base_ff <= base_in;
      end
   end

   // Corner pipeline: read, weight, accumulate
   always_ff @(posedge clock) begin
      v1_ff    <= cmd.issue;
      v2_ff    <= v1_ff;
      wac_ff   <= wac_in;
      dk_ff    <= cmd.corner[0];
      w_ff     <= w_in;
      data2_ff <= rd_data_ff;
      if (cmd.base) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(w_ff) * ACC_W'(data2_ff);
      end
      if (cmd.load_out) begin
         out_ff <= cfg.table_ready ? acc_ff[ACC_W-1:24] : 16'd0;
      end
   end

   assign rsp_pot_probability = out_ff;

endmodule
